// ----- rtl/wdss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdss_pkg
// Shared types and constants of the winner-take-all disparity selector.
// ----------------------------------------------------------------------------
package wdss_pkg;

    // Fixed field widths
    localparam int MINW       = 16;  // running minimum and second minimum
    localparam int CFG_W      = 9;   // widest configuration register
    localparam int CFG_IDX_W  = 2;   // configuration register index
    localparam int DISPW      = 18;  // signed Q.8 disparity
    localparam int FRAC_BITS  = 8;   // fraction bits of the disparity
    localparam int HALF_SHIFT = 7;   // numerator scale of 128

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIQ_EN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNIQ_RATIO = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_MIN_DISP   = 9'd0;
    localparam logic [CFG_W-1:0] RST_DISP_COUNT = 9'd64;
    localparam logic             RST_UNIQ_EN    = 1'b1;
    localparam logic [CFG_W-1:0] RST_UNIQ_RATIO = 9'd243;

    // Ratio of one in Q1.8
    localparam logic [CFG_W-1:0] RATIO_ONE = 9'd256;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // take the offered cost item
        logic capture;   // latch the finished pixel into the finisher
        logic prep;      // form threshold, numerator and denominator
        logic step;      // one divider iteration
        logic load_out;  // load the result into the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_item; // the next item ends the pixel
        logic div_last;  // the divider runs its final iteration
        logic out_free;  // the output register can take a result
    } sts_t;

endpackage
`default_nettype wire

// ----- rtl/wdss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdss_ctrl
// Controller: input handshake and the per-pixel finishing sequence
// (prepare, divide, deliver).
// ----------------------------------------------------------------------------
module wdss_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wdss_pkg::sts_t     sts,
    output wdss_pkg::cmd_t     cmd
);
    import wdss_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Stall only an item that ends a pixel while the finisher is busy
    assign in_ready = !sts.last_item || (state_reg == S_IDLE);

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        cmd.accept     = in_valid && in_ready;
        cmd.capture    = in_valid && in_ready && sts.last_item;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A pixel is captured only when the finisher is free
    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (state_reg == S_IDLE))
        else $error("pixel captured while finisher busy");

    // Preparation leads into the divider in the next cycle
    a_prep_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |=> (state_reg == S_DIV))
        else $error("prepare did not lead to divide");

    // A finished result waits while the output register is occupied
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !sts.out_free) |=> (state_reg == S_DONE))
        else $error("result dropped while output busy");

endmodule
`default_nettype wire

// ----- rtl/wdss_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdss_datapath
// Datapath: configuration registers, running minimum tracking, finisher
// registers, uniqueness threshold, restoring divider and output register.
// ----------------------------------------------------------------------------
module wdss_datapath #(
    parameter int MAX_DISPARITIES = 256,
    parameter int COST_BITS       = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wdss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wdss_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic [COST_BITS-1:0]           cost,
    input  wdss_pkg::cmd_t                      cmd,
    output wdss_pkg::sts_t                      sts,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic                                valid_res,
    output logic signed [wdss_pkg::DISPW-1:0]   disparity_q8,
    output logic [COST_BITS-1:0]                best_cost
);
    import wdss_pkg::*;

    localparam int IDXW  = $clog2(MAX_DISPARITIES);
    localparam int CLOGM = $clog2(MAX_DISPARITIES + 1);
    localparam int CNTW  = (CLOGM > CFG_W) ? CLOGM : CFG_W;
    localparam int NUMW  = COST_BITS + HALF_SHIFT;
    localparam int DENW  = COST_BITS + 1;
    localparam int SW    = COST_BITS + 3;
    localparam int DCW   = $clog2(NUMW + 1);
    localparam int PRODW = MINW + CFG_W;
    localparam int THRW  = PRODW - FRAC_BITS;

    // Configuration registers
    logic [CFG_W-1:0] min_disp_reg;
    logic [CFG_W-1:0] disp_count_reg;
    logic             uniq_en_reg;
    logic [CFG_W-1:0] uniq_ratio_reg;

    // Per-pixel tracking state
    logic [IDXW-1:0]      idx_reg,    idx_next;
    logic [MINW-1:0]      min_reg,    min_next;
    logic [MINW-1:0]      second_reg, second_next;
    logic [IDXW-1:0]      best_reg,   best_next;
    logic [COST_BITS-1:0] prev_reg,   prev_next;
    logic [COST_BITS-1:0] before_reg, before_next;
    logic [COST_BITS-1:0] after_reg,  after_next;
    logic                 pend_reg,   pend_next;

    // Finisher registers
    logic [MINW-1:0]      f_min_reg;
    logic [MINW-1:0]      f_second_reg;
    logic [IDXW-1:0]      f_best_reg;
    logic [COST_BITS-1:0] f_before_reg;
    logic [COST_BITS-1:0] f_after_reg;
    logic                 f_border_reg;
    logic                 f_uen_reg;
    logic [CFG_W-1:0]     f_ratio_reg;
    logic [CFG_W-1:0]     f_mindisp_reg;
    logic [THRW-1:0]      thr_reg;
    logic                 neg_reg;
    logic [DENW-1:0]      den_reg;
    logic [DENW-1:0]      rem_reg;
    logic [NUMW-1:0]      quo_reg;
    logic [DCW-1:0]       div_cnt_reg;

    // Output register
    logic                 out_valid_reg;
    logic                 valid_res_reg;
    logic [DISPW-1:0]     disp_reg;
    logic [COST_BITS-1:0] best_cost_reg;

    // Combinational helpers
    logic [CNTW-1:0]      cnt_raw;
    logic [CNTW-1:0]      cnt_sat;
    logic [MINW-1:0]      cost_ext;
    logic                 border;
    logic [CFG_W-1:0]     ratio_sat;
    logic [PRODW-1:0]     prod;
    logic [SW-1:0]        den_s;
    logic [COST_BITS-1:0] mag;
    logic [DENW:0]        trial;
    logic                 fit;
    logic [MINW-1:0]      gap;
    logic                 uniq_fail;
    logic                 res_valid;
    logic [DISPW-1:0]     base;
    logic [DISPW-1:0]     quo_s;
    logic [DISPW-1:0]     disp_sum;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_disp_reg   <= RST_MIN_DISP;
            disp_count_reg <= RST_DISP_COUNT;
            uniq_en_reg    <= RST_UNIQ_EN;
            uniq_ratio_reg <= RST_UNIQ_RATIO;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_DISP:   min_disp_reg   <= cfg_wdata;
                REG_DISP_COUNT: disp_count_reg <= cfg_wdata;
                REG_UNIQ_EN:    uniq_en_reg    <= cfg_wdata[0];
                REG_UNIQ_RATIO: uniq_ratio_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Saturate the disparity count to MAX_DISPARITIES; a count of zero becomes one
    always_comb
    begin
        cnt_raw = CNTW'(disp_count_reg);
        if (cnt_raw == '0)
        begin
            cnt_sat = CNTW'(1);
        end
        else if (cnt_raw > CNTW'(MAX_DISPARITIES))
        begin
            cnt_sat = CNTW'(MAX_DISPARITIES);
        end
        else
        begin
            cnt_sat = cnt_raw;
        end
    end

    // Detect the pixel's last item
    assign sts.last_item = (CNTW'(idx_reg) + CNTW'(1)) >= cnt_sat;

    // Update minimum, second minimum and the neighbors of the minimum; flag a border winner and saturate the ratio
    always_comb
    begin
        cost_ext    = MINW'(cost);
        min_next    = min_reg;
        second_next = second_reg;
        best_next   = best_reg;
        before_next = before_reg;
        after_next  = after_reg;
        pend_next   = pend_reg;
        prev_next   = cost;
        idx_next    = idx_reg + IDXW'(1);
        if (cost_ext < min_reg)
        begin
            second_next = min_reg;
            min_next    = cost_ext;
            best_next   = idx_reg;
            before_next = (idx_reg != '0) ? prev_reg : '0;
            after_next  = '0;
            pend_next   = 1'b1;
        end
        else
        begin
            if (cost_ext < second_reg)
            begin
                second_next = cost_ext;
            end
            if (pend_reg)
            begin
                after_next = cost;
                pend_next  = 1'b0;
            end
        end
        border = (best_next == '0) || (CNTW'(best_next) == (cnt_sat - CNTW'(1)));
        ratio_sat = (uniq_ratio_reg > RATIO_ONE) ? RATIO_ONE : uniq_ratio_reg;
    end

    // Advance tracking; clear it when a pixel ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            min_reg    <= '1;
            second_reg <= '1;
            best_reg   <= '0;
            prev_reg   <= '0;
            before_reg <= '0;
            after_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else if (cmd.capture)
        begin
            idx_reg    <= '0;
            min_reg    <= '1;
            second_reg <= '1;
            best_reg   <= '0;
            prev_reg   <= '0;
            before_reg <= '0;
            after_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            idx_reg    <= idx_next;
            min_reg    <= min_next;
            second_reg <= second_next;
            best_reg   <= best_next;
            prev_reg   <= prev_next;
            before_reg <= before_next;
            after_reg  <= after_next;
            pend_reg   <= pend_next;
        end
    end

    // Latch the finished pixel
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            f_min_reg     <= min_next;
            f_second_reg  <= second_next;
            f_best_reg    <= best_next;
            f_before_reg  <= before_next;
            f_after_reg   <= after_next;
            f_border_reg  <= border;
            f_uen_reg     <= uniq_en_reg;
            f_ratio_reg   <= ratio_sat;
            f_mindisp_reg <= min_disp_reg;
        end
    end

    // Threshold product, denominator, numerator magnitude and the divider trial
    always_comb
    begin
        prod  = PRODW'(f_min_reg) * PRODW'(RATIO_ONE - f_ratio_reg);
        den_s = SW'(f_before_reg) + SW'(f_after_reg)
              - (SW'(f_min_reg[COST_BITS-1:0]) << 1);
        mag   = (f_before_reg >= f_after_reg) ? (f_before_reg - f_after_reg)
                                              : (f_after_reg - f_before_reg);
        trial = {rem_reg, quo_reg[NUMW-1]};
        fit   = trial >= {1'b0, den_reg};
    end

    // Prepare the divider, then run one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.prep)
        begin
            div_cnt_reg <= DCW'(NUMW);
        end
        else if (cmd.step)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            thr_reg <= prod[PRODW-1:FRAC_BITS];
            neg_reg <= f_after_reg > f_before_reg;
            if (!den_s[SW-1] && (den_s != '0))
            begin
                den_reg <= den_s[DENW-1:0];
            end
            else
            begin
                den_reg <= DENW'(1);
            end
            rem_reg <= '0;
            quo_reg <= {mag, {HALF_SHIFT{1'b0}}};
        end
        else if (cmd.step)
        begin
            if (fit)
            begin
                rem_reg <= DENW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DENW-1:0];
            end
            quo_reg <= {quo_reg[NUMW-2:0], fit};
        end
    end

    assign sts.div_last = (div_cnt_reg == DCW'(1));

    // Uniqueness, border and the final Q.8 disparity (modulo the field width)
    always_comb
    begin
        gap       = f_second_reg - f_min_reg;
        uniq_fail = f_uen_reg && (THRW'(gap) <= thr_reg);
        res_valid = !uniq_fail && !f_border_reg;
        base      = ({{(DISPW-CFG_W){f_mindisp_reg[CFG_W-1]}}, f_mindisp_reg}
                    + DISPW'(f_best_reg)) << FRAC_BITS;
        quo_s     = neg_reg ? (DISPW'(0) - DISPW'(quo_reg)) : DISPW'(quo_reg);
        disp_sum  = base + quo_s;
    end

    // Hold the result until it is taken
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            valid_res_reg <= res_valid;
            disp_reg      <= res_valid ? disp_sum : '0;
            best_cost_reg <= f_min_reg[COST_BITS-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = valid_res_reg;
    assign disparity_q8 = $signed(disp_reg);
    assign best_cost    = best_cost_reg;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // Divider steps only with iterations left
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (div_cnt_reg != '0))
        else $error("divider stepped past its last bit");

    // A loaded result is offered in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not offered");

endmodule
`default_nettype wire

// ----- rtl/wta_disparity_subpixel_select_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wta_disparity_subpixel_select_top
// Winner-take-all disparity selection with uniqueness test and parabola
// subpixel refinement over a stream of per-disparity costs.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction  Handshake
//  input     cost                                      in         in_valid/in_ready
//  output    valid_res, disparity_q8, best_cost        out        out_valid/out_ready
//  config    cfg_index, cfg_wdata                      in         cfg_wr_en
//
//  Cost items are taken one per cycle. The item that ends a pixel stalls while
//  the finisher still works on the previous pixel: capture, prepare, restoring
//  divider (one quotient bit per iteration) and deliver, in that order.
//  Reset loads the register defaults and clears the tracking state; no sweep.
//  A result held in the output register stalls the finisher, and through it the item that ends the next pixel.
// ----------------------------------------------------------------------------
module wta_disparity_subpixel_select_top #(
    parameter int MAX_DISPARITIES = 256,
    parameter int COST_BITS       = 12
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wdss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wdss_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [COST_BITS-1:0]           cost,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                valid_res,
    output logic signed [wdss_pkg::DISPW-1:0]   disparity_q8,
    output logic [COST_BITS-1:0]                best_cost
);
    import wdss_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the finishing steps
    wdss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Track costs and compute the result
    wdss_datapath #(
        .MAX_DISPARITIES (MAX_DISPARITIES),
        .COST_BITS       (COST_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cost         (cost),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .valid_res    (valid_res),
        .disparity_q8 (disparity_q8),
        .best_cost    (best_cost)
    );

endmodule
`default_nettype wire

// ----- test/wta_disparity_subpixel_select_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wta_disparity_subpixel_select_top_tb
// Streams per-disparity cost items into the winner-take-all selector and
// checks every pixel result against a cycle-free model of the minimum search,
// the uniqueness test, the border rule and the parabola subpixel fit. Runs
// directed pixels first, then random configurations and pixel shapes under
// varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module wta_disparity_subpixel_select_top_tb;
    import wdss_pkg::*;

    localparam int COST_W      = 12;
    localparam int MAX_DISP    = 256;
    localparam int DRAIN_CYC   = 2 * (COST_W + 9) + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int RAND_ITEMS  = 150;
    localparam int RAND_PIXELS = 14;
    localparam logic [MINW-1:0] NO_COST = '1;

    typedef enum int { PIX_VALLEY, PIX_RANDOM, PIX_TIE, PIX_BORDER, PIX_FLAT } pixel_kind_e;
    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_e;

    typedef struct packed {
        logic               valid_res;
        logic [DISPW-1:0]   disparity_q8;
        logic [COST_W-1:0]  best_cost;
    } disp_result_t;

    typedef int cost_list_t[$];

    // DUT signals, all inputs known from time zero
    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [COST_W-1:0]       cost      = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    valid_res;
    logic signed [DISPW-1:0] disparity_q8;
    logic [COST_W-1:0]       best_cost;

    // Register copies
    logic signed [CFG_W-1:0] cfg_min_disp = RST_MIN_DISP;
    logic [CFG_W-1:0]        cfg_count    = RST_DISP_COUNT;
    logic                    cfg_uniq_en  = RST_UNIQ_EN;
    logic [CFG_W-1:0]        cfg_ratio    = RST_UNIQ_RATIO;

    // Per-pixel tracking copy
    int                      trk_counter  = 0;
    logic [MINW-1:0]         trk_min      = NO_COST;
    logic [MINW-1:0]         trk_min2     = NO_COST;
    int                      trk_best_idx = 0;
    logic [COST_W-1:0]       trk_prev     = '0;
    logic [COST_W-1:0]       trk_before   = '0;
    logic [COST_W-1:0]       trk_after    = '0;
    bit                      trk_pending  = 1'b0;

    disp_result_t disp_due[$];

    int err_count      = 0;
    int cycle_count    = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    wta_disparity_subpixel_select_top #(
        .MAX_DISPARITIES (MAX_DISP),
        .COST_BITS       (COST_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cost         (cost),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .disparity_q8 (disparity_q8),
        .best_cost    (best_cost)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                     disp_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Effective item count of one pixel
    function automatic int pixel_len();
        int n;
        n = cfg_count;
        if (n == 0)
            n = 1;
        if (n > MAX_DISP)
            n = MAX_DISP;
        return n;
    endfunction

    // Track one accepted cost item; queue the pixel result after the last one
    task automatic track_cost(input logic [COST_W-1:0] c);
        int           n;
        int           idx;
        int unsigned  ratio;
        int unsigned  thr;
        int unsigned  m;
        int unsigned  m2;
        bit           ok;
        longint       c1;
        longint       c2;
        longint       den;
        longint       disp;
        disp_result_t r;
        n   = pixel_len();
        idx = trk_counter;
        if (c < trk_min)
        begin
            trk_min2     = trk_min;
            trk_min      = c;
            trk_best_idx = idx;
            trk_before   = (idx > 0) ? trk_prev : '0;
            trk_after    = '0;
            trk_pending  = 1'b1;
        end
        else
        begin
            if (c < trk_min2)
                trk_min2 = c;
            if (trk_pending)
            begin
                trk_after   = c;
                trk_pending = 1'b0;
            end
        end
        trk_prev = c;

        if (idx + 1 < n)
        begin
            trk_counter = idx + 1;
            return;
        end

        // Uniqueness test, then border rule
        ok = 1'b1;
        if (cfg_uniq_en)
        begin
            ratio = (cfg_ratio > RATIO_ONE) ? 256 : cfg_ratio;
            m     = trk_min;
            m2    = trk_min2;
            thr   = (m * (256 - ratio)) >> FRAC_BITS;
            if (m2 - m <= thr)
                ok = 1'b0;
        end
        if (ok && (trk_best_idx == 0 || trk_best_idx == n - 1))
            ok = 1'b0;

        // Parabola fit, quotient truncated toward zero
        disp = 0;
        if (ok)
        begin
            c1  = trk_before;
            c2  = trk_after;
            den = c1 + c2 - 2 * longint'(trk_min);
            if (den < 1)
                den = 1;
            disp = (longint'(cfg_min_disp) + trk_best_idx) * 256
                   + ((c1 - c2) * (longint'(1) << HALF_SHIFT)) / den;
        end
        r.valid_res    = ok;
        r.disparity_q8 = ok ? disp[DISPW-1:0] : '0;
        r.best_cost    = trk_min[COST_W-1:0];
        disp_due.push_back(r);

        // Clear for the next pixel
        trk_counter  = 0;
        trk_min      = NO_COST;
        trk_min2     = NO_COST;
        trk_best_idx = 0;
        trk_prev     = '0;
        trk_before   = '0;
        trk_after    = '0;
        trk_pending  = 1'b0;
    endtask

    // Check each accepted result against the oldest one due; randomize ready
    always @(posedge clk)
    begin : result_check
        disp_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen = results_seen + 1;
            if (disp_due.size() == 0)
            begin
                err_count = err_count + 1;
                if (err_count <= MAX_REPORTS)
                    $display("Unexpected result at cycle %0d: valid_res=%0b disparity_q8=%0d best_cost=%0d",
                             cycle_count, valid_res, disparity_q8, best_cost);
            end
            else
            begin
                want = disp_due.pop_front();
                if (want.valid_res !== valid_res || want.disparity_q8 !== disparity_q8 ||
                    want.best_cost !== best_cost)
                begin
                    err_count = err_count + 1;
                    if (err_count <= MAX_REPORTS)
                        $display("Mismatch at cycle %0d: expected valid_res=%0b disparity_q8=%0d best_cost=%0d, got valid_res=%0b disparity_q8=%0d best_cost=%0d",
                                 cycle_count, want.valid_res, $signed(want.disparity_q8),
                                 want.best_cost, valid_res, disparity_q8, best_cost);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            IDLE_BOTH: begin send_idle_pct = 29; recv_stall_pct = 29; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Write all four registers back to back; only called while idle
    task automatic set_config(input int md, input int cnt, input int en, input int ratio);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MIN_DISP;
        cfg_wdata <= md[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_DISP_COUNT;
        cfg_wdata <= cnt[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= REG_UNIQ_EN;
        cfg_wdata <= CFG_W'(en & 1);
        @(posedge clk);
        cfg_index <= REG_UNIQ_RATIO;
        cfg_wdata <= ratio[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_min_disp = md[CFG_W-1:0];
        cfg_count    = cnt[CFG_W-1:0];
        cfg_uniq_en  = en[0];
        cfg_ratio    = ratio[CFG_W-1:0];
        @(posedge clk);
    endtask

    // Offer one cost item, with an optional gap ahead of it
    task automatic send_cost(input logic [COST_W-1:0] c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        cost     <= c;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent = items_sent + 1;
        track_cost(c);
    endtask

    task automatic send_costs(input cost_list_t costs);
        foreach (costs[i])
            send_cost(COST_W'(costs[i]));
    endtask

    // Drop valid, wait for every due result, then let the finisher settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (disp_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Build and send one pixel of the current length
    task automatic send_pixel(input pixel_kind_e kind);
        int         n;
        int         m;
        int         m2;
        int         base;
        int         k;
        int         d;
        int         v;
        cost_list_t q;
        n    = pixel_len();
        base = $urandom_range(0, 4000);
        k    = $urandom_range(1, 200);
        m2   = -1;
        if ((kind == PIX_VALLEY || kind == PIX_TIE) && n < 3)
            kind = PIX_RANDOM;
        if (kind == PIX_BORDER)
            m = $urandom_range(0, 1) ? 0 : n - 1;
        else if (n >= 3)
            m = $urandom_range(1, n - 2);
        else
            m = 0;
        if (kind == PIX_TIE)
            m2 = (m + $urandom_range(1, n - 1)) % n;
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                PIX_RANDOM: v = $urandom_range(0, 4095);
                PIX_FLAT:   v = base;
                default:
                begin
                    d = i - m;
                    v = (i == m || i == m2) ? base : base + k * d * d + $urandom_range(0, k - 1);
                    if (v > 4095)
                        v = 4095;
                end
            endcase
            q.push_back(v);
        end
        send_costs(q);
    endtask

    // Pixels at the register defaults
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        repeat (2) send_pixel(PIX_VALLEY);
        wait_drained();
    endtask

    // Cost and disparity extremes, flat pixel, border winners
    task automatic test_extremes();
        set_idling(IDLE_NONE);
        set_config(-256, 3, 0, 243);
        send_costs('{4095, 0, 4095});
        send_costs('{0, 0, 0});
        wait_drained();
        set_idling(IDLE_BOTH);
        set_config(255, 3, 0, 0);
        send_costs('{4095, 4094, 0});
        send_costs('{100, 0, 4095});
        wait_drained();
    endtask

    // Single-item pixels, zero count taken as one
    task automatic test_count_limits();
        set_idling(IDLE_SEND);
        set_config(0, 1, 1, 243);
        send_costs('{7});
        send_costs('{4095});
        wait_drained();
        set_config(-1, 0, 1, 243);
        send_costs('{0});
        wait_drained();
    endtask

    // Ties, ratio of one and above, strict ratio, test disabled
    task automatic test_uniqueness();
        set_idling(IDLE_RECV);
        set_config(0, 4, 1, 256);
        send_costs('{50, 10, 10, 60});
        wait_drained();
        set_config(0, 4, 1, 511);
        send_costs('{50, 10, 10, 60});
        wait_drained();
        set_idling(IDLE_BOTH);
        set_config(0, 4, 1, 0);
        send_costs('{120, 100, 110, 130});
        send_costs('{200, 20, 60, 200});
        wait_drained();
        set_config(0, 4, 0, 243);
        send_costs('{50, 10, 10, 60});
        wait_drained();
    endtask

    // Random registers and pixel shapes, phases rotating through idling modes
    task automatic test_random_phases();
        int item_start;
        int res_start;
        int phase_no;
        int md;
        int cnt;
        int ratio;
        int pick;
        // Widest range once, count saturated from above
        set_idling(IDLE_BOTH);
        set_config(255, 511, 1, 243);
        send_pixel(PIX_VALLEY);
        wait_drained();

        item_start = items_sent;
        res_start  = results_seen;
        phase_no   = 0;
        while (items_sent - item_start < RAND_ITEMS || results_seen - res_start < RAND_PIXELS)
        begin
            set_idling(idle_mode_e'(phase_no % 4));
            case ($urandom_range(0, 3))
                0:       md = -256;
                1:       md = 255;
                default: md = int'($urandom_range(0, 511)) - 256;
            endcase
            case ($urandom_range(0, 19))
                0:       cnt = 0;
                1:       cnt = 1;
                2:       cnt = 3;
                default: cnt = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 5))
                0:       ratio = 0;
                1:       ratio = 243;
                2:       ratio = 256;
                3:       ratio = 511;
                default: ratio = $urandom_range(0, 511);
            endcase
            set_config(md, cnt, ($urandom_range(0, 3) != 0), ratio);
            repeat ($urandom_range(4, 10))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    send_pixel(PIX_VALLEY);
                else if (pick < 75)
                    send_pixel(PIX_RANDOM);
                else if (pick < 85)
                    send_pixel(PIX_TIE);
                else if (pick < 95)
                    send_pixel(PIX_BORDER);
                else
                    send_pixel(PIX_FLAT);
            end
            wait_drained();
            phase_no = phase_no + 1;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extremes();
        test_count_limits();
        test_uniqueness();
        test_random_phases();
        wait_drained();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
